/* src/sqau_pkg.sv */
// Shared types and constants for the stack/queue arithmetic unit.
// Used by sqau_div, sqau_ram and stack_queue_arith_unit; depends on nothing.
`timescale 1ns / 1ps

package sqau_pkg;

  localparam int WORD_W = 32;
  localparam int REQ_W  = 4;
  localparam int ST_W   = 2;

  // Request codes (item kind on the input tuser)
  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH  = 4'd0,
    REQ_POP   = 4'd1,
    REQ_PEEK  = 4'd2,
    REQ_ADD   = 4'd3,
    REQ_SUB   = 4'd4,
    REQ_MUL   = 4'd5,
    REQ_DIV   = 4'd6,
    REQ_MOD   = 4'd7,
    REQ_CLEAR = 4'd8
  } req_e;

  // Result status codes
  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_SHORT   = 2'd1,
    ST_DIVZERO = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RD1,
    S_RD2,
    S_CALC,
    S_DIV,
    S_WB,
    S_OUT
  } state_e;

  // Divider request and response
  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [WORD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] quot;
    logic [WORD_W-1:0] rem;
  } div_rsp_t;

endpackage

/* src/sqau_ram.sv */
// Word store: one write port, one read port, registered read data.
// Depends on sqau_pkg for the word width.
`timescale 1ns / 1ps

module sqau_ram #(
  parameter int DEPTH = 64,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                      clk_i,
  input  logic                      wr_en_i,
  input  logic [IDX_W-1:0]          wr_addr_i,
  input  logic [sqau_pkg::WORD_W-1:0] wr_data_i,
  input  logic [IDX_W-1:0]          rd_addr_i,
  output logic [sqau_pkg::WORD_W-1:0] rd_data_o
);

  logic [sqau_pkg::WORD_W-1:0] mem_q [DEPTH];
  logic [sqau_pkg::WORD_W-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

/* src/sqau_div.sv */
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on sqau_pkg for the word width and request/response structs.
`timescale 1ns / 1ps

module sqau_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sqau_pkg::div_req_t  req_i,
  output sqau_pkg::div_rsp_t  rsp_o
);

  localparam int W     = sqau_pkg::WORD_W;
  localparam int CNT_W = $clog2(W);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [W-1:0]     rem_q, rem_d;
  logic [W-1:0]     quo_q, quo_d;
  logic [W-1:0]     dvs_q, dvs_d;
  logic             negq_q, negq_d;
  logic             negr_q, negr_d;

  logic [W:0]       trial;
  logic             fits;
  logic             na, nb;

  assign na    = req_i.dividend[W-1];
  assign nb    = req_i.divisor[W-1];
  assign trial = {rem_q, quo_q[W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  // control
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // datapath: magnitudes on start, shift-subtract step while busy
  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    negq_d = negq_q;
    negr_d = negr_q;
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = na ? (W'(0) - req_i.dividend) : req_i.dividend;
      dvs_d  = nb ? (W'(0) - req_i.divisor) : req_i.divisor;
      negq_d = na ^ nb;
      negr_d = na;
    end else if (busy_q) begin
      rem_d = fits ? W'(trial - {1'b0, dvs_q}) : trial[W-1:0];
      quo_d = {quo_q[W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    dvs_q  <= dvs_d;
    negq_q <= negq_d;
    negr_q <= negr_d;
  end

  // sign correction
  assign rsp_o.done = done_q;
  assign rsp_o.quot = negq_q ? (W'(0) - quo_q) : quo_q;
  assign rsp_o.rem  = negr_q ? (W'(0) - rem_q) : rem_q;

endmodule

/* src/stack_queue_arith_unit.sv */
// Top level: request sequencer around the word store and the divider.
// Depends on sqau_pkg, sqau_ram and sqau_div.
//
//  channel   dir  handshake                   payload
//  s_axis    in   s_axis_tvalid/tready        tuser: req_type; tdata: push_value
//  m_axis    out  m_axis_tvalid/tready        tuser: status;
//                                             tdata: result_value, element_count
//  cfg       in   cfg_valid_i/cfg_ready_o     cfg_data_i: queue_mode
//
// One item at a time. Push, clear and unused codes go from accept via EXEC to
// OUT; pop and peek add RD1; add/sub/mul add RD1, RD2, CALC and WB; div and
// mod also wait in DIV for the bit-serial divider. The store read is registered.
// Reset clears pointers, count and mode; store contents are left undefined.
// A new item is taken while the previous result waits in the output register;
// the sequencer holds its result until the output register is free.
`timescale 1ns / 1ps

module stack_queue_arith_unit #(
  parameter int DEPTH = 64,
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W   = $clog2(DEPTH + 1),
  localparam int OTDAT_W = ((sqau_pkg::WORD_W + CNT_W + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [sqau_pkg::WORD_W-1:0]   s_axis_tdata,  // [31:0] push_value
  input  logic [sqau_pkg::REQ_W-1:0]    s_axis_tuser,  // [3:0] req_type
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [OTDAT_W-1:0]            m_axis_tdata,  // [31:0] result_value,
                                                       // then element_count
  output logic [sqau_pkg::ST_W-1:0]     m_axis_tuser,  // [1:0] status
  // mode register write
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_data_i     // queue_mode
);

  localparam int W = sqau_pkg::WORD_W;

  sqau_pkg::state_e  state_q, state_d;
  sqau_pkg::status_e res_st_q, res_st_d;
  sqau_pkg::status_e m_st_q, m_st_d;

  logic [sqau_pkg::REQ_W-1:0] req_q, req_d;
  logic [W-1:0]     pv_q, pv_d;
  logic [W-1:0]     f_q, f_d;
  logic [W-1:0]     s_q, s_d;
  logic [W-1:0]     res_val_q, res_val_d;
  logic [IDX_W-1:0] front_q, front_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             mode_q;
  logic             m_valid_q, m_valid_d;
  logic [W-1:0]     m_val_q, m_val_d;
  logic [CNT_W-1:0] m_cnt_q, m_cnt_d;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [W-1:0]     wr_data;
  logic [IDX_W-1:0] rd_addr;
  logic [W-1:0]     rd_data;

  sqau_pkg::div_req_t div_req;
  sqau_pkg::div_rsp_t div_rsp;

  logic             is_arith, is_divmod, is_take;
  logic             out_free;
  logic [IDX_W-1:0] front_inc, front_inc2, front_dec, tail;
  logic [IDX_W+1:0] tail_sum;

  // ------------------------------------------------------------------
  // request decode and circular index arithmetic
  always_comb begin
    is_arith  = req_q inside {sqau_pkg::REQ_ADD, sqau_pkg::REQ_SUB, sqau_pkg::REQ_MUL,
                              sqau_pkg::REQ_DIV, sqau_pkg::REQ_MOD};
    is_divmod = req_q inside {sqau_pkg::REQ_DIV, sqau_pkg::REQ_MOD};
    is_take   = req_q inside {sqau_pkg::REQ_POP, sqau_pkg::REQ_PEEK};
  end

  assign front_inc  = (front_q == IDX_W'(DEPTH - 1)) ? '0 : front_q + 1'b1;
  assign front_inc2 = (front_inc == IDX_W'(DEPTH - 1)) ? '0 : front_inc + 1'b1;
  assign front_dec  = (front_q == '0) ? IDX_W'(DEPTH - 1) : front_q - 1'b1;
  assign tail_sum   = (IDX_W + 2)'(front_q) + (IDX_W + 2)'(count_q);
  assign tail       = (tail_sum >= (IDX_W + 2)'(DEPTH)) ?
                      IDX_W'(tail_sum - (IDX_W + 2)'(DEPTH)) : IDX_W'(tail_sum);

  assign out_free = !m_valid_q || m_axis_tready;

  // ------------------------------------------------------------------
  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sqau_pkg::S_IDLE: if (s_axis_tvalid) state_d = sqau_pkg::S_EXEC;
      sqau_pkg::S_EXEC: begin
        if (is_take && count_q != '0) begin
          state_d = sqau_pkg::S_RD1;
        end else if (is_arith && count_q >= CNT_W'(2)) begin
          state_d = sqau_pkg::S_RD1;
        end else begin
          state_d = sqau_pkg::S_OUT;
        end
      end
      sqau_pkg::S_RD1: begin
        if (is_take || (is_divmod && rd_data == '0)) begin
          state_d = sqau_pkg::S_OUT;
        end else begin
          state_d = sqau_pkg::S_RD2;
        end
      end
      sqau_pkg::S_RD2:  state_d = sqau_pkg::S_CALC;
      sqau_pkg::S_CALC: state_d = is_divmod ? sqau_pkg::S_DIV : sqau_pkg::S_WB;
      sqau_pkg::S_DIV:  if (div_rsp.done) state_d = sqau_pkg::S_WB;
      sqau_pkg::S_WB:   state_d = sqau_pkg::S_OUT;
      sqau_pkg::S_OUT:  if (out_free) state_d = sqau_pkg::S_IDLE;
      default:          state_d = sqau_pkg::S_IDLE;
    endcase
  end

  // ------------------------------------------------------------------
  // datapath and store accesses per state
  always_comb begin
    req_d     = req_q;
    pv_d      = pv_q;
    f_d       = f_q;
    s_d       = s_q;
    res_val_d = res_val_q;
    res_st_d  = res_st_q;
    front_d   = front_q;
    count_d   = count_q;
    wr_en     = 1'b0;
    wr_addr   = front_q;
    wr_data   = pv_q;
    rd_addr   = front_q;
    div_req   = '{start: 1'b0, dividend: s_q, divisor: f_q};

    case (state_q)
      sqau_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          req_d = s_axis_tuser;
          pv_d  = s_axis_tdata;
        end
      end
      sqau_pkg::S_EXEC: begin
        res_val_d = '0;
        res_st_d  = sqau_pkg::ST_OK;
        case (req_q)
          sqau_pkg::REQ_PUSH: begin
            if (count_q == CNT_W'(DEPTH)) begin
              res_st_d = sqau_pkg::ST_FULL;
            end else begin
              wr_en   = 1'b1;
              count_d = count_q + 1'b1;
              if (mode_q) begin
                wr_addr = tail;
              end else begin
                wr_addr = front_dec;
                front_d = front_dec;
              end
            end
          end
          sqau_pkg::REQ_POP, sqau_pkg::REQ_PEEK: begin
            if (count_q == '0) res_st_d = sqau_pkg::ST_SHORT;
          end
          sqau_pkg::REQ_ADD, sqau_pkg::REQ_SUB, sqau_pkg::REQ_MUL,
          sqau_pkg::REQ_DIV, sqau_pkg::REQ_MOD: begin
            if (count_q < CNT_W'(2)) res_st_d = sqau_pkg::ST_SHORT;
          end
          sqau_pkg::REQ_CLEAR: begin
            front_d = '0;
            count_d = '0;
          end
          default: ;
        endcase
      end
      // front word arrives; fetch the second one
      sqau_pkg::S_RD1: begin
        f_d     = rd_data;
        rd_addr = front_inc;
        if (req_q == sqau_pkg::REQ_POP) begin
          res_val_d = rd_data;
          front_d   = front_inc;
          count_d   = count_q - 1'b1;
        end else if (req_q == sqau_pkg::REQ_PEEK) begin
          res_val_d = rd_data;
        end else if (is_divmod && rd_data == '0) begin
          res_st_d = sqau_pkg::ST_DIVZERO;
        end
      end
      sqau_pkg::S_RD2: s_d = rd_data;
      sqau_pkg::S_CALC: begin
        case (req_q)
          sqau_pkg::REQ_ADD: res_val_d = s_q + f_q;
          sqau_pkg::REQ_SUB: res_val_d = s_q - f_q;
          sqau_pkg::REQ_MUL: res_val_d = W'(s_q * f_q);
          default:           div_req.start = 1'b1;
        endcase
      end
      sqau_pkg::S_DIV: begin
        if (div_rsp.done) begin
          res_val_d = (req_q == sqau_pkg::REQ_MOD) ? div_rsp.rem : div_rsp.quot;
        end
      end
      // two words taken, result put back under the current order
      sqau_pkg::S_WB: begin
        wr_en   = 1'b1;
        wr_data = res_val_q;
        count_d = count_q - 1'b1;
        if (mode_q) begin
          wr_addr = tail;
          front_d = front_inc2;
        end else begin
          wr_addr = front_inc;
          front_d = front_inc;
        end
      end
      default: ;
    endcase
  end

  // ------------------------------------------------------------------
  // output register
  always_comb begin
    m_valid_d = m_valid_q;
    m_val_d   = m_val_q;
    m_st_d    = m_st_q;
    m_cnt_d   = m_cnt_q;
    if (state_q == sqau_pkg::S_OUT && out_free) begin
      m_valid_d = 1'b1;
      m_val_d   = res_val_q;
      m_st_d    = res_st_q;
      m_cnt_d   = count_q;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  // ------------------------------------------------------------------
  // registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sqau_pkg::S_IDLE;
      front_q   <= '0;
      count_q   <= '0;
      mode_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      front_q   <= front_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
      if (cfg_valid_i) begin
        mode_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    pv_q      <= pv_d;
    f_q       <= f_d;
    s_q       <= s_d;
    res_val_q <= res_val_d;
    res_st_q  <= res_st_d;
    m_val_q   <= m_val_d;
    m_st_q    <= m_st_d;
    m_cnt_q   <= m_cnt_d;
  end

  // ------------------------------------------------------------------
  // word store and divider
  sqau_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  sqau_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // ports
  assign s_axis_tready = (state_q == sqau_pkg::S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OTDAT_W'({m_cnt_q, m_val_q});
  assign m_axis_tuser  = m_st_q;

endmodule

/* verif/stack_queue_arith_unit_test.sv */
// Self-checking testbench for stack_queue_arith_unit: stack and queue order,
// arithmetic and error statuses, mode writes, full-store back-pressure.
// Depends on sqau_pkg and the stack_queue_arith_unit RTL only.
`timescale 1ns / 1ps

module stack_queue_arith_unit_test;

  localparam int DEPTH       = 64;
  localparam int CNT_W       = 7;
  localparam int OTDAT_W     = 40;
  localparam int HOLD_CYCLES = 200;   // long receiver hold-off
  localparam int STALL_LIMIT = 2000;  // cycles without any handshake
  localparam int DRAIN_WAIT  = 64;    // quiet time after the last result
  localparam int MAX_REPORTS = 10;

  localparam logic [sqau_pkg::REQ_W-1:0] UNUSED_FIRST = 4'd9;
  localparam logic [sqau_pkg::REQ_W-1:0] UNUSED_LAST  = 4'd15;
  localparam logic [sqau_pkg::WORD_W-1:0] WORD_MAX = 32'h7fff_ffff;
  localparam logic [sqau_pkg::WORD_W-1:0] WORD_MIN = 32'h8000_0000;
  localparam logic [sqau_pkg::WORD_W-1:0] MINUS_ONE = 32'hffff_ffff;

  typedef struct packed {
    logic [sqau_pkg::WORD_W-1:0] value;
    sqau_pkg::status_e           status;
    logic [CNT_W-1:0]            count;
  } stack_result_t;

  // DUT connections, inputs all known from time zero
  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [sqau_pkg::WORD_W-1:0]   s_axis_tdata = '0;   // [31:0] push_value
  logic [sqau_pkg::REQ_W-1:0]    s_axis_tuser = '0;   // [3:0] req_type
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [OTDAT_W-1:0]            m_axis_tdata;  // [31:0] result_value, [38:32] element_count
  logic [sqau_pkg::ST_W-1:0]     m_axis_tuser;  // [1:0] status
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic                          cfg_data_i = 1'b0;

  // Predicted store state
  logic [sqau_pkg::WORD_W-1:0] word_mem [DEPTH];
  logic [5:0]                  front_idx = '0;
  logic [CNT_W-1:0]            word_cnt = '0;
  bit                          queue_mode_q = 1'b0;

  stack_result_t pending_results [$];
  stack_result_t want_result;
  int            error_count = 0;
  int            idle_cycles = 0;
  int            rx_hold_cycles = 0;
  bit            tx_idle_on = 1'b1;
  bit            rx_idle_on = 1'b1;

  stack_queue_arith_unit #(.DEPTH(DEPTH)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor

  // Stack order puts new words at the front, queue order at the tail.
  function automatic void put_word(logic [sqau_pkg::WORD_W-1:0] w);
    logic [5:0] slot;
    if (queue_mode_q) begin
      slot = front_idx + word_cnt[5:0];
      word_mem[slot] = w;
    end else begin
      front_idx = front_idx - 1'b1;
      word_mem[front_idx] = w;
    end
    word_cnt = word_cnt + 1'b1;
  endfunction

  function automatic logic [sqau_pkg::WORD_W-1:0] take_word();
    logic [sqau_pkg::WORD_W-1:0] w;
    w = word_mem[front_idx];
    front_idx = front_idx + 1'b1;
    word_cnt = word_cnt - 1'b1;
    return w;
  endfunction

  // Truncating signed divide on magnitudes; MIN / -1 wraps back to MIN.
  function automatic logic [sqau_pkg::WORD_W-1:0] trunc_divide(
      logic [sqau_pkg::WORD_W-1:0] num,
      logic [sqau_pkg::WORD_W-1:0] den,
      bit want_rem);
    logic [sqau_pkg::WORD_W-1:0] mag_n, mag_d, quo, rmd;
    mag_n = num[31] ? -num : num;
    mag_d = den[31] ? -den : den;
    quo = mag_n / mag_d;
    rmd = mag_n % mag_d;
    if (want_rem) return num[31] ? -rmd : rmd;
    return (num[31] ^ den[31]) ? -quo : quo;
  endfunction

  function automatic stack_result_t apply_request(logic [sqau_pkg::REQ_W-1:0] req,
                                                  logic [sqau_pkg::WORD_W-1:0] operand);
    stack_result_t               r;
    logic [sqau_pkg::WORD_W-1:0] f, s;
    r.value  = '0;
    r.status = sqau_pkg::ST_OK;
    case (req)
      sqau_pkg::REQ_PUSH: begin
        if (word_cnt >= DEPTH) r.status = sqau_pkg::ST_FULL;
        else put_word(operand);
      end
      sqau_pkg::REQ_POP, sqau_pkg::REQ_PEEK: begin
        if (word_cnt == 0) r.status = sqau_pkg::ST_SHORT;
        else if (req == sqau_pkg::REQ_POP) r.value = take_word();
        else r.value = word_mem[front_idx];
      end
      sqau_pkg::REQ_ADD, sqau_pkg::REQ_SUB, sqau_pkg::REQ_MUL,
      sqau_pkg::REQ_DIV, sqau_pkg::REQ_MOD: begin
        if (word_cnt < 2) begin
          r.status = sqau_pkg::ST_SHORT;
        end else if ((req == sqau_pkg::REQ_DIV || req == sqau_pkg::REQ_MOD) &&
                     word_mem[front_idx] == '0) begin
          r.status = sqau_pkg::ST_DIVZERO;
        end else begin
          // result is second op front
          f = take_word();
          s = take_word();
          case (req)
            sqau_pkg::REQ_ADD: r.value = s + f;
            sqau_pkg::REQ_SUB: r.value = s - f;
            sqau_pkg::REQ_MUL: r.value = s * f;
            sqau_pkg::REQ_DIV: r.value = trunc_divide(s, f, 1'b0);
            default:           r.value = trunc_divide(s, f, 1'b1);
          endcase
          put_word(r.value);
        end
      end
      sqau_pkg::REQ_CLEAR: begin
        front_idx = '0;
        word_cnt  = '0;
      end
      default: ;  // unused codes do nothing
    endcase
    r.count = word_cnt;
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic logic [sqau_pkg::WORD_W-1:0] random_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return WORD_MAX;
      2:       return WORD_MIN;
      3:       return MINUS_ONE;
      4:       return 32'($urandom_range(0, 20)) - 32'd10;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [sqau_pkg::REQ_W-1:0] pick_request(int push_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < push_pct) return sqau_pkg::REQ_PUSH;
    if (roll < push_pct + 8) return sqau_pkg::REQ_POP;
    if (roll < push_pct + 12) return sqau_pkg::REQ_PEEK;
    if (roll < push_pct + 14) return sqau_pkg::REQ_CLEAR;
    if (roll < push_pct + 16) return 4'($urandom_range(UNUSED_FIRST, UNUSED_LAST));
    case ($urandom_range(0, 4))
      0:       return sqau_pkg::REQ_ADD;
      1:       return sqau_pkg::REQ_SUB;
      2:       return sqau_pkg::REQ_MUL;
      3:       return sqau_pkg::REQ_DIV;
      default: return sqau_pkg::REQ_MOD;
    endcase
  endfunction

  function automatic void note_failure(string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  // Offer one item, wait for the handshake, record its predicted result.
  task automatic send_item(logic [sqau_pkg::REQ_W-1:0] req,
                           logic [sqau_pkg::WORD_W-1:0] operand);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= operand;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(apply_request(req, operand));
  endtask

  // Stop offering and wait until every predicted result has been checked.
  task automatic settle_outstanding();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic write_queue_mode(bit mode);
    settle_outstanding();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= mode;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    queue_mode_q = mode;
  endtask

  // ---------------------------------------------------------------- tests

  // Pop, peek and add on an empty store, plus the extreme unused code and a clear
  task automatic test_empty_store();
    send_item(sqau_pkg::REQ_POP, WORD_MAX);
    send_item(sqau_pkg::REQ_PEEK, WORD_MIN);
    send_item(sqau_pkg::REQ_ADD, '0);
    send_item(UNUSED_LAST, MINUS_ONE);
    send_item(sqau_pkg::REQ_CLEAR, '0);
  endtask

  // Stack order: wrap, MIN / -1, MIN % -1, divide by zero, pop and peek
  task automatic test_stack_arith();
    send_item(sqau_pkg::REQ_PUSH, WORD_MAX);
    send_item(sqau_pkg::REQ_ADD, '0);           // one word only
    send_item(sqau_pkg::REQ_PUSH, 32'd1);
    send_item(sqau_pkg::REQ_ADD, '0);           // wraps to MIN
    send_item(sqau_pkg::REQ_PUSH, MINUS_ONE);
    send_item(sqau_pkg::REQ_DIV, '0);
    send_item(sqau_pkg::REQ_PUSH, MINUS_ONE);
    send_item(sqau_pkg::REQ_MOD, '0);
    send_item(sqau_pkg::REQ_PUSH, '0);
    send_item(sqau_pkg::REQ_DIV, '0);           // zero divisor
    send_item(sqau_pkg::REQ_MOD, '0);
    send_item(sqau_pkg::REQ_POP, '0);
    send_item(sqau_pkg::REQ_PEEK, '0);
    send_item(sqau_pkg::REQ_CLEAR, '0);
  endtask

  // Queue order, then a mode change with words still held
  task automatic test_queue_order();
    write_queue_mode(1'b1);
    send_item(sqau_pkg::REQ_PUSH, 32'd7);
    send_item(sqau_pkg::REQ_PUSH, 32'd3);
    send_item(sqau_pkg::REQ_SUB, '0);
    send_item(sqau_pkg::REQ_PUSH, WORD_MIN);
    send_item(sqau_pkg::REQ_MUL, '0);
    write_queue_mode(1'b0);
    send_item(sqau_pkg::REQ_PUSH, 32'd5);
    send_item(sqau_pkg::REQ_POP, '0);
    send_item(sqau_pkg::REQ_POP, '0);
    send_item(sqau_pkg::REQ_CLEAR, '0);
  endtask

  task automatic test_random_traffic(bit mode, int count);
    int k;
    write_queue_mode(mode);
    for (k = 0; k < count; k++)
      send_item(pick_request((word_cnt < 4) ? 65 : 45), random_word());
  endtask

  // Fill past the full mark while the result side is held off, so the
  // input stalls; then pause until all results are in and work near full.
  task automatic test_full_store(bit mode);
    int k;
    write_queue_mode(mode);
    send_item(sqau_pkg::REQ_CLEAR, random_word());
    tx_idle_on = 1'b0;
    rx_hold_cycles = HOLD_CYCLES;
    for (k = 0; k < DEPTH + 6; k++) send_item(sqau_pkg::REQ_PUSH, random_word());
    settle_outstanding();
    tx_idle_on = 1'b1;
    for (k = 0; k < 40; k++) send_item(pick_request(55), random_word());
  endtask

  // Toggle the order repeatedly while words are held
  task automatic test_mode_switching();
    int round;
    for (round = 0; round < 8; round++) test_random_traffic(round[0], 30);
  endtask

  task automatic test_no_idle();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    test_random_traffic(1'($urandom_range(0, 1)), 250);
  endtask

  // ---------------------------------------------------------------- processes

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_store();
    test_stack_arith();
    test_queue_order();
    test_random_traffic(1'b0, 350);
    test_random_traffic(1'b1, 350);
    test_full_store(1'b0);
    test_full_store(1'b1);
    test_mode_switching();
    test_no_idle();
    settle_outstanding();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (pending_results.size() != 0)
      note_failure($sformatf("%0d results never arrived", pending_results.size()));
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Result side: random stalls, plus the long hold-off on request
  initial begin
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (rx_hold_cycles != 0) begin
        m_axis_tready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk_i);
        rx_hold_cycles = 0;
        m_axis_tready <= 1'b1;
      end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        note_failure($sformatf("unexpected result: value %h status %0d count %0d",
                               m_axis_tdata[31:0], m_axis_tuser, m_axis_tdata[38:32]));
      end else begin
        want_result = pending_results.pop_front();
        if (m_axis_tdata[31:0] !== want_result.value ||
            m_axis_tuser !== want_result.status ||
            m_axis_tdata[38:32] !== want_result.count)
          note_failure($sformatf(
            "mismatch: expected value %h status %0d count %0d, got %h %0d %0d",
            want_result.value, want_result.status, want_result.count,
            m_axis_tdata[31:0], m_axis_tuser, m_axis_tdata[38:32]));
      end
    end
  end

  // Watchdog on cycles with no handshake anywhere
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule
